// ===== sv/csv_field_tokenizer_core_assert.svh =====
// Assertion macros for the CSV field tokenizer core.
`ifndef CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSVFT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");
`define CSVFT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle check");
`else
`define CSVFT_ASSERT_ALWAYS(label, clk, rst, expr)
`define CSVFT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== sv/csvft_pkg.sv =====
// Package with constants and item types of the CSV field tokenizer.
`timescale 1ns / 1ps
package csvft_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_WIDTH = 2;

   localparam logic [7:0] SEPARATOR_RESET = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LINE_FEED = 8'h0A;
   localparam logic [7:0] CHAR_CARRIAGE_RETURN = 8'h0D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic end_of_input;
      logic [31:0] line_offset;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] field_length;
      logic [15:0] field_index;
      logic [31:0] field_offset;
      logic line_closed;
      logic run_last;
   } rsp_payload_type;

endpackage

// ===== sv/csv_field_tokenizer_core.sv =====
// CSV field tokenizer: splits a byte stream into field descriptors.
// Each result item enters the result queue at the clock edge that accepts its byte.
// Throughput: one byte per cycle while the queue has room; results leave one at a time
// through the single output port of the four-entry result queue.
// Bytes are stalled while fewer than two queue entries are free.
// Reset is synchronous and active high; it clears the line state and sets the separator to comma.
`timescale 1ns / 1ps
`include "csv_field_tokenizer_core_assert.svh"
module csv_field_tokenizer_core #(
   parameter int COUNT_WIDTH = csvft_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  csvft_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output csvft_pkg::rsp_payload_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int PTR_W = csvft_pkg::FIFO_PTR_WIDTH;
   localparam int CNT_W = PTR_W + 1;

   logic [7:0] separator_ff;
   logic in_quotes_ff, in_quotes_in;
   logic prev_backslash_ff, prev_backslash_in;
   logic prev_cr_ff, prev_cr_in;
   logic first_pending_ff, first_pending_in;
   logic line_finished_ff, line_finished_in;
   logic [COUNT_WIDTH-1:0] current_length_ff, current_length_in;
   logic [COUNT_WIDTH-1:0] current_index_ff, current_index_in;
   logic [COUNT_WIDTH-1:0] byte_position_ff, byte_position_in;
   logic [COUNT_WIDTH-1:0] field_start_ff, field_start_in;
   logic [31:0] base_offset_ff, base_offset_in;

   csvft_pkg::rsp_payload_type fifo_ff [csvft_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic req_accept, rsp_pop;
   logic [1:0] n_res;
   csvft_pkg::rsp_payload_type res0, res1;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == {COUNT_WIDTH{1'b1}}) ? v : v + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
   endfunction

   function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic csvft_pkg::rsp_payload_type make_rsp(
      input logic [COUNT_WIDTH-1:0] len,
      input logic [COUNT_WIDTH-1:0] idx,
      input logic [31:0] base,
      input logic [COUNT_WIDTH-1:0] start,
      input logic closed
   );
      csvft_pkg::rsp_payload_type r;
      r.field_length = sat16(len);
      r.field_index = sat16(idx);
      r.field_offset = base + 32'(start);
      r.line_closed = closed;
      r.run_last = 1'b0;
      return r;
   endfunction

   assign req_stall = reset || (count_ff > CNT_W'(csvft_pkg::FIFO_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_pop = rsp_valid && !rsp_stall;
   assign rsp_payload = fifo_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      logic [7:0] b;
      logic lf;
      logic [COUNT_WIDTH-1:0] out_len;
      b = req_payload.data_byte;
      lf = 1'b0;
      out_len = current_length_ff;
      in_quotes_in = in_quotes_ff;
      prev_backslash_in = prev_backslash_ff;
      prev_cr_in = prev_cr_ff;
      first_pending_in = first_pending_ff;
      line_finished_in = line_finished_ff;
      current_length_in = current_length_ff;
      current_index_in = current_index_ff;
      byte_position_in = byte_position_ff;
      field_start_in = field_start_ff;
      base_offset_in = base_offset_ff;
      n_res = 2'd0;
      res0 = make_rsp(current_length_ff, current_index_ff, base_offset_ff, field_start_ff, 1'b0);
      res1 = res0;
      if (req_accept) begin
         if (!line_finished_ff) begin
            if (first_pending_ff) begin
               base_offset_in = req_payload.line_offset;
               first_pending_in = 1'b0;
            end
            byte_position_in = sat_inc(byte_position_ff);
            if (b == csvft_pkg::CHAR_QUOTE) begin
               if (prev_backslash_ff) begin
                  current_length_in = (current_length_ff == '0) ?
                     {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : current_length_ff;
               end else begin
                  in_quotes_in = !in_quotes_ff;
                  current_length_in = sat_inc(current_length_ff);
               end
            end else if (b == csvft_pkg::CHAR_LINE_FEED || b == separator_ff) begin
               if (in_quotes_ff) begin
                  current_length_in = sat_inc(current_length_ff);
               end else begin
                  lf = b == csvft_pkg::CHAR_LINE_FEED;
                  if (lf && prev_cr_ff && current_length_ff != '0) begin
                     out_len = current_length_ff - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                  end
                  res0 = make_rsp(out_len, current_index_ff, base_offset_in,
                     field_start_ff, lf);
                  n_res = 2'd1;
                  field_start_in = byte_position_in;
                  current_index_in = sat_inc(current_index_ff);
                  current_length_in = '0;
                  if (lf) begin
                     line_finished_in = 1'b1;
                  end
               end
            end else begin
               current_length_in = sat_inc(current_length_ff);
            end
            prev_backslash_in = b == csvft_pkg::CHAR_BACKSLASH;
            prev_cr_in = b == csvft_pkg::CHAR_CARRIAGE_RETURN;
         end
         if (req_payload.end_of_input) begin
            if (!line_finished_in) begin
               if (n_res == 2'd0) begin
                  res0 = make_rsp(current_length_in, current_index_in, base_offset_in,
                     field_start_in, 1'b1);
                  n_res = 2'd1;
               end else begin
                  res1 = make_rsp(current_length_in, current_index_in, base_offset_in,
                     field_start_in, 1'b1);
                  n_res = 2'd2;
               end
            end
            in_quotes_in = 1'b0;
            prev_backslash_in = 1'b0;
            prev_cr_in = 1'b0;
            first_pending_in = 1'b1;
            line_finished_in = 1'b0;
            current_length_in = '0;
            current_index_in = '0;
            byte_position_in = '0;
            field_start_in = '0;
            base_offset_in = '0;
         end
         if (n_res == 2'd1) begin
            res0.run_last = 1'b1;
         end
         if (n_res == 2'd2) begin
            res1.run_last = 1'b1;
         end
      end
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_res);
      rd_ptr_in = rsp_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(n_res) - CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= csvft_pkg::SEPARATOR_RESET;
         in_quotes_ff <= 1'b0;
         prev_backslash_ff <= 1'b0;
         prev_cr_ff <= 1'b0;
         first_pending_ff <= 1'b1;
         line_finished_ff <= 1'b0;
         current_length_ff <= '0;
         current_index_ff <= '0;
         byte_position_ff <= '0;
         field_start_ff <= '0;
         base_offset_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            separator_ff <= csr_write_data;
         end
         in_quotes_ff <= in_quotes_in;
         prev_backslash_ff <= prev_backslash_in;
         prev_cr_ff <= prev_cr_in;
         first_pending_ff <= first_pending_in;
         line_finished_ff <= line_finished_in;
         current_length_ff <= current_length_in;
         current_index_ff <= current_index_in;
         byte_position_ff <= byte_position_in;
         field_start_ff <= field_start_in;
         base_offset_ff <= base_offset_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ptr_next] <= res1;
      end
   end

   `CSVFT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(csvft_pkg::FIFO_DEPTH))
   `CSVFT_ASSERT_ALWAYS(a_finished_clean, clock, reset,
      !line_finished_ff || (current_length_ff == '0 && !in_quotes_ff))
   `CSVFT_ASSERT_NEXT(a_eoi_resets, clock, reset, req_accept && req_payload.end_of_input,
      first_pending_ff && !line_finished_ff && current_index_ff == '0)
   `CSVFT_ASSERT_NEXT(a_pop_count, clock, reset, rsp_pop && n_res == 2'd0,
      count_ff == $past(count_ff) - CNT_W'(1))

endmodule

// ===== tb/sv/tb_csv_field_tokenizer_core.sv =====
// Self-checking testbench that feeds bytes to the CSV field tokenizer core.
`timescale 1ns / 1ps
module tb_csv_field_tokenizer_core;

   typedef struct {
      bit is_csr;
      logic [7:0] sep;
      csvft_pkg::req_payload_type req;
      int typed_n;
      csvft_pkg::rsp_payload_type typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   csvft_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   csvft_pkg::rsp_payload_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   logic [7:0] tk_sep;
   bit tk_in_quotes;
   bit tk_after_backslash;
   bit tk_after_cr;
   bit tk_line_start;
   bit tk_line_done;
   logic [15:0] tk_len;
   logic [15:0] tk_idx;
   logic [15:0] tk_pos;
   logic [15:0] tk_start;
   logic [31:0] tk_base;

   csvft_pkg::rsp_payload_type field_expect_q[$];
   csvft_pkg::rsp_payload_type field_want;
   stim_row_type directed_rows[$];
   int fail_count = 0;
   int items_sent = 0;
   int fields_checked = 0;
   int csr_writes = 0;
   int stall_left = 0;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;

   csv_field_tokenizer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] sat_count(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic csvft_pkg::rsp_payload_type field_descriptor(input bit closed);
      csvft_pkg::rsp_payload_type r;
      r.field_length = tk_len;
      r.field_index = tk_idx;
      r.field_offset = tk_base + {16'h0000, tk_start};
      r.line_closed = closed;
      r.run_last = 1'b0;
      return r;
   endfunction

   task automatic clear_line_state();
      tk_in_quotes = 1'b0;
      tk_after_backslash = 1'b0;
      tk_after_cr = 1'b0;
      tk_line_start = 1'b1;
      tk_line_done = 1'b0;
      tk_len = '0;
      tk_idx = '0;
      tk_pos = '0;
      tk_start = '0;
      tk_base = '0;
   endtask

   task automatic tokenize_byte(input csvft_pkg::req_payload_type p, input bit keep);
      csvft_pkg::rsp_payload_type made[$];
      bit is_lf;
      logic [7:0] b;
      b = p.data_byte;
      if (!tk_line_done) begin
         if (tk_line_start) begin
            tk_base = p.line_offset;
            tk_line_start = 1'b0;
         end
         tk_pos = sat_count(tk_pos);
         if (b == csvft_pkg::CHAR_QUOTE) begin
            if (tk_after_backslash) begin
               if (tk_len != 0) tk_len = tk_len - 16'd1;
            end else begin
               tk_in_quotes = !tk_in_quotes;
            end
            tk_len = sat_count(tk_len);
         end else if (b == csvft_pkg::CHAR_LINE_FEED || b == tk_sep) begin
            if (tk_in_quotes) begin
               tk_len = sat_count(tk_len);
            end else begin
               is_lf = (b == csvft_pkg::CHAR_LINE_FEED);
               if (is_lf && tk_after_cr && tk_len != 0) tk_len = tk_len - 16'd1;
               made.push_back(field_descriptor(is_lf));
               tk_start = tk_pos;
               tk_idx = sat_count(tk_idx);
               tk_len = '0;
               if (is_lf) tk_line_done = 1'b1;
            end
         end else begin
            tk_len = sat_count(tk_len);
         end
         tk_after_backslash = (b == csvft_pkg::CHAR_BACKSLASH);
         tk_after_cr = (b == csvft_pkg::CHAR_CARRIAGE_RETURN);
      end
      if (p.end_of_input) begin
         if (!tk_line_done) made.push_back(field_descriptor(1'b1));
         clear_line_state();
      end
      if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
      if (keep) begin
         foreach (made[i]) field_expect_q.push_back(made[i]);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input csvft_pkg::req_payload_type p, input bit keep);
      int gap;
      gap = send_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      tokenize_byte(p, keep);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (field_expect_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_separator(input logic [7:0] v);
      pause_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tk_sep = v;
      csr_writes++;
   endtask

   function automatic logic [7:0] pick_line_byte();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0, 1: return tk_sep;
         2: return csvft_pkg::CHAR_QUOTE;
         3: return csvft_pkg::CHAR_BACKSLASH;
         4: return csvft_pkg::CHAR_CARRIAGE_RETURN;
         5: return csvft_pkg::CHAR_LINE_FEED;
         6, 7: return 8'($urandom_range(0, 255));
         default: return 8'h61 + 8'($urandom_range(0, 25));
      endcase
   endfunction

   task automatic send_random_line();
      logic [7:0] bytes_q[$];
      csvft_pkg::req_payload_type p;
      repeat ($urandom_range(0, 13)) bytes_q.push_back(pick_line_byte());
      if ($urandom_range(0, 3) == 0) begin
         bytes_q.push_back(csvft_pkg::CHAR_CARRIAGE_RETURN);
         bytes_q.push_back(csvft_pkg::CHAR_LINE_FEED);
         repeat ($urandom_range(0, 2)) bytes_q.push_back(pick_line_byte());
      end
      bytes_q.push_back(pick_line_byte());
      foreach (bytes_q[i]) begin
         p.data_byte = bytes_q[i];
         p.end_of_input = (i == bytes_q.size() - 1);
         p.line_offset = $urandom();
         send_item(p, 1'b1);
      end
   endtask

   function automatic stim_row_type row_byte(input logic [7:0] b, input bit e,
                                             input logic [31:0] o);
      stim_row_type r;
      r.is_csr = 1'b0;
      r.sep = 8'h00;
      r.req = csvft_pkg::req_payload_type'{data_byte: b, end_of_input: e, line_offset: o};
      r.typed_n = -1;
      r.typed = '0;
      return r;
   endfunction

   function automatic stim_row_type row_typed(input logic [7:0] b, input bit e,
                                              input logic [31:0] o, input int n,
                                              input logic [15:0] len,
                                              input logic [15:0] idx, input logic [31:0] foff,
                                              input bit closed);
      stim_row_type r;
      r = row_byte(b, e, o);
      r.typed_n = n;
      r.typed = csvft_pkg::rsp_payload_type'{field_length: len, field_index: idx,
                                             field_offset: foff, line_closed: closed,
                                             run_last: 1'b1};
      return r;
   endfunction

   function automatic stim_row_type row_sep(input logic [7:0] v);
      stim_row_type r;
      r = row_byte(8'h00, 1'b0, 32'h0);
      r.is_csr = 1'b1;
      r.sep = v;
      return r;
   endfunction

   task automatic check_value(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (field_expect_q.size() == 0) begin
            $error("unexpected field descriptor %h", rsp_payload);
            fail_count++;
         end else begin
            field_want = field_expect_q.pop_front();
            check_value("field_length", 32'(field_want.field_length),
                        32'(rsp_payload.field_length));
            check_value("field_index", 32'(field_want.field_index),
                        32'(rsp_payload.field_index));
            check_value("field_offset", field_want.field_offset, rsp_payload.field_offset);
            check_value("line_closed", 32'(field_want.line_closed),
                        32'(rsp_payload.line_closed));
            check_value("run_last", 32'(field_want.run_last), 32'(rsp_payload.run_last));
            fields_checked++;
         end
         stall_left = recv_idle ? $urandom_range(0, 4) : 0;
      end else if (rsp_valid && rsp_stall && stall_left != 0) begin
         stall_left--;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_left != 0);
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      stim_row_type row;
      logic [7:0] sep;
      int phase;
      int phase_start;
      int random_start;
      bit paused;

      tk_sep = csvft_pkg::SEPARATOR_RESET;
      clear_line_state();

      // Quoted separators, an escaped quote, a dropped carriage return and ignored tail bytes.
      directed_rows.push_back(row_typed(8'h61, 1'b0, 32'h0000_0100, 0, 16'd0, 16'd0, 32'h0,
                                        1'b0));
      directed_rows.push_back(row_typed(csvft_pkg::SEPARATOR_RESET, 1'b0, 32'h0, 1, 16'd1,
                                        16'd0, 32'h0000_0100, 1'b0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::SEPARATOR_RESET, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_BACKSLASH, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_CARRIAGE_RETURN, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_LINE_FEED, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(8'h78, 1'b0, 32'h0));
      directed_rows.push_back(row_typed(8'hFF, 1'b1, 32'hFFFF_FFFF, 0, 16'd0, 16'd0, 32'h0,
                                        1'b0));
      // A quote on the first byte, then a separator on the last byte.
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'hFFFF_FFFF));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_LINE_FEED, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::SEPARATOR_RESET, 1'b1, 32'h0));
      directed_rows.push_back(row_typed(8'h00, 1'b1, 32'h0, 1, 16'd1, 16'd0, 32'h0, 1'b1));
      // Backslash as separator gives an escaped quote on an empty count.
      directed_rows.push_back(row_sep(csvft_pkg::CHAR_BACKSLASH));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_BACKSLASH, 1'b0, 32'h8000_0000));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'h0));
      directed_rows.push_back(row_byte(csvft_pkg::SEPARATOR_RESET, 1'b1, 32'h0));
      // Carriage return as separator leaves nothing to drop at the line feed.
      directed_rows.push_back(row_sep(csvft_pkg::CHAR_CARRIAGE_RETURN));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_CARRIAGE_RETURN, 1'b0, 32'h0000_1234));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_LINE_FEED, 1'b0, 32'h0));
      directed_rows.push_back(row_typed(8'h41, 1'b1, 32'h0, 0, 16'd0, 16'd0, 32'h0, 1'b0));
      directed_rows.push_back(row_sep(csvft_pkg::CHAR_QUOTE));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_QUOTE, 1'b0, 32'h5555_AAAA));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_LINE_FEED, 1'b1, 32'h0));
      directed_rows.push_back(row_sep(csvft_pkg::CHAR_LINE_FEED));
      directed_rows.push_back(row_byte(8'h61, 1'b0, 32'hAAAA_5555));
      directed_rows.push_back(row_byte(csvft_pkg::CHAR_LINE_FEED, 1'b1, 32'h0));
      directed_rows.push_back(row_sep(8'hFF));
      directed_rows.push_back(row_byte(8'hFF, 1'b1, 32'hFFFF_FFFF));
      directed_rows.push_back(row_sep(8'h00));
      directed_rows.push_back(row_byte(8'h00, 1'b1, 32'h7FFF_FFFF));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            write_separator(row.sep);
         end else begin
            send_item(row.req, row.typed_n < 0);
            if (row.typed_n > 0) field_expect_q.push_back(row.typed);
         end
      end

      phase = 0;
      paused = 1'b0;
      random_start = items_sent;
      while (items_sent - random_start < 1350) begin
         case (phase % 8)
            0: sep = csvft_pkg::SEPARATOR_RESET;
            1: sep = 8'h3B;
            2: sep = 8'($urandom_range(0, 255));
            3: sep = csvft_pkg::CHAR_QUOTE;
            4: sep = 8'hFF;
            5: sep = csvft_pkg::CHAR_BACKSLASH;
            6: sep = 8'h00;
            default: sep = csvft_pkg::CHAR_LINE_FEED;
         endcase
         write_separator(sep);
         send_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         recv_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         phase_start = items_sent;
         while (items_sent - phase_start < 170) begin
            if (phase == 2 && !paused && items_sent - phase_start >= 90) begin
               pause_until_drained();
               paused = 1'b1;
            end
            send_random_line();
         end
         phase++;
      end

      pause_until_drained();
      repeat (8) @(negedge clock);

      $display("Sent %0d bytes over %0d separator settings and checked %0d field descriptors,",
               items_sent, csr_writes, fields_checked);
      $display("including quoting, escapes, dropped carriage returns and ignored tail bytes.");
      if (fail_count == 0 && field_expect_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (field_expect_q.size() != 0)
            $error("%0d field descriptors never arrived", field_expect_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
